/* rtl/y2b_pkg.sv */
// Shared types, constants and register codes of the YUY2 to BGRA converter.
`default_nettype none

package y2b_pkg;

   // Configuration register geometry
   localparam int CSR_DATA_WIDTH    = 13;
   localparam int DEFAULT_MAX_WIDTH = 4096;
   localparam int HEIGHT_LIMIT      = 4096;
   localparam int RESET_WIDTH       = 1920;
   localparam int RESET_HEIGHT      = 1080;
   localparam int ROW_WIDTH         = 12;

   // Register indexes
   typedef enum logic [0:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Conversion arithmetic
   localparam int SUM_WIDTH = 20;
   localparam logic signed [SUM_WIDTH-1:0] COEF_Y    = 20'sd298;
   localparam logic signed [SUM_WIDTH-1:0] COEF_R_CR = 20'sd409;
   localparam logic signed [SUM_WIDTH-1:0] COEF_G_CB = 20'sd100;
   localparam logic signed [SUM_WIDTH-1:0] COEF_G_CR = 20'sd208;
   localparam logic signed [SUM_WIDTH-1:0] COEF_B_CB = 20'sd516;
   localparam logic signed [SUM_WIDTH-1:0] ROUND     = 20'sd128;
   localparam logic [7:0] LUMA_OFFSET   = 8'd16;
   localparam logic [7:0] CHROMA_OFFSET = 8'd128;
   localparam logic [7:0] ALPHA_OPAQUE  = 8'd255;

   // One YUY2 macropixel
   typedef struct packed {
      logic [7:0] luma0;
      logic [7:0] chroma_blue;
      logic [7:0] luma1;
      logic [7:0] chroma_red;
   } in_type;

   // One BGRA pixel with position flags
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       end_of_row;
      logic       end_of_frame;
      logic       last;
   } out_type;

   // Classified macropixel handed from front to back
   typedef struct packed {
      in_type pix;
      logic   two;
      logic   eor;
      logic   eof;
   } work_type;

endpackage

`default_nettype wire

/* rtl/yuy2_to_bgra_stream.sv */
// Top level of the YUY2 to BGRA stream converter.
`default_nettype none

// Converts packed YUY2 macropixels (luma0, Cb, luma1, Cr) in raster order into
// BGRA pixels with BT.601 integer coefficients, each channel saturated to
// 0..255 and alpha fixed at 255. Each macropixel gives two result beats, or one
// when it ends an odd-width row; end_of_row, end_of_frame and last mark the
// position. The result port delivers one pixel per cycle while results are
// taken; a two-entry queue lets short bursts of input go in on consecutive
// cycles. A pixel is registered onto the result port from the head of the
// queue once the result register is free, so an accepted macropixel passes
// through a queue slot and the result register before it reaches the port.
// Any write to frame_width or frame_height restarts the frame at column 0,
// row 0; a width or height of 0 counts as 1, larger values clamp to MAX_WIDTH
// and 4096. Write configuration only while no results are pending.
module yuy2_to_bgra_stream
   import y2b_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_en,
   input  wire csr_index_type             csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data,
   input  wire logic                      req_push,
   input  wire in_type                    req_data,
   output logic                           req_full,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output out_type                        rsp_data
);

   logic     q_push, q_full, q_pop, q_empty;
   work_type q_in, q_head;

   y2b_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_push     (req_push),
      .req_data     (req_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_data       (q_in)
   );

   y2b_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   y2b_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   assign req_full = q_full;

   // End of frame only on the closing pixel of a row and of its macropixel
   a_eof_closes_row: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.end_of_frame |-> rsp_data.end_of_row && rsp_data.last)
      else $error("end_of_frame without end_of_row and last");

   // A single-pixel macropixel only occurs at a row end
   a_single_at_row_end: assert property (@(posedge clock) disable iff (reset)
      !q_empty && !q_head.two |-> q_head.eor)
      else $error("single-pixel macropixel away from row end");

   // Right after reset the result port is empty and the queue is not full
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> rsp_empty && !req_full)
      else $error("result or queue occupied after reset");

   // A queued macropixel reaches the result port on the next free cycle
   a_no_stall_back: assert property (@(posedge clock) disable iff (reset)
      !q_empty && rsp_empty |=> !rsp_empty)
      else $error("back end idled with work queued");

endmodule

`default_nettype wire

/* rtl/y2b_front.sv */
// Front end: geometry registers, column and row counters, macropixel classification.
`default_nettype none

module y2b_front
   import y2b_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_en,
   input  wire csr_index_type             csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data,
   input  wire logic                      req_push,
   input  wire in_type                    req_data,
   input  wire logic                      q_full,
   output logic                           q_push,
   output work_type                       q_data
);

   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int XW  = WW + 1;
   localparam int RW0 = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

   logic [WW-1:0]             width_ff, width_in;
   logic [CSR_DATA_WIDTH-1:0] height_ff, height_in;
   logic [CW-1:0]             col_ff, col_in;
   logic [ROW_WIDTH-1:0]      row_ff, row_in;
   logic [XW-1:0]             col_x, width_x;
   logic [CSR_DATA_WIDTH:0]   row_x, height_x;
   logic                      two, eor, eof;

   // Clamp a written width to 1..MAX_WIDTH and a height to 1..HEIGHT_LIMIT
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               if (csr_data == '0) begin
                  width_in = WW'(1);
               end else if (32'(csr_data) > MAX_WIDTH) begin
                  width_in = WW'(MAX_WIDTH);
               end else begin
                  width_in = WW'(csr_data);
               end
            end
            REG_FRAME_HEIGHT: begin
               if (csr_data == '0) begin
                  height_in = CSR_DATA_WIDTH'(1);
               end else if (32'(csr_data) > HEIGHT_LIMIT) begin
                  height_in = CSR_DATA_WIDTH'(HEIGHT_LIMIT);
               end else begin
                  height_in = csr_data;
               end
            end
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   // Classify the incoming macropixel against the frame position
   always_comb begin
      col_x    = XW'(col_ff);
      width_x  = XW'(width_ff);
      row_x    = (CSR_DATA_WIDTH + 1)'(row_ff);
      height_x = (CSR_DATA_WIDTH + 1)'(height_ff);
      two      = (col_x + XW'(1)) < width_x;
      eor      = (col_x + (two ? XW'(2) : XW'(1))) >= width_x;
      eof      = eor && ((row_x + (CSR_DATA_WIDTH + 1)'(1)) >= height_x);
   end

   assign q_push       = req_push && !q_full;
   assign q_data.pix   = req_data;
   assign q_data.two   = two;
   assign q_data.eor   = eor;
   assign q_data.eof   = eof;

   // Advance the counters on each beat, restart the frame on any register write
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_write_en) begin
         col_in = '0;
         row_in = '0;
      end else if (q_push) begin
         if (eor) begin
            col_in = '0;
            row_in = eof ? '0 : row_ff + ROW_WIDTH'(1);
         end else begin
            col_in = col_ff + CW'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WW'(RW0);
         height_ff <= CSR_DATA_WIDTH'(RESET_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/y2b_fifo.sv */
// Two-entry queue of classified macropixels between front and back.
`default_nettype none

module y2b_fifo
   import y2b_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire work_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output work_type      head
);

   work_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = count_ff == 2'd2;
   assign empty   = count_ff == 2'd0;
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* rtl/y2b_back.sv */
// Back end: BT.601 color conversion, one pixel per cycle unless stalled, into the result register.
`default_nettype none

module y2b_back
   import y2b_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire work_type q_head,
   output logic          q_pop,
   output logic          rsp_empty,
   input  wire logic     rsp_pop,
   output out_type       rsp_data
);

   logic                        sel_ff, sel_in;
   logic                        valid_ff, valid_in;
   out_type                     out_ff, out_in;
   logic                        load, final_pix;
   logic [7:0]                  luma;
   logic signed [8:0]           c, d, e;
   logic signed [SUM_WIDTH-1:0] c_x, d_x, e_x, sum_b, sum_g, sum_r;

   function automatic logic [7:0] sat8(input logic signed [SUM_WIDTH-1:0] s);
      logic [7:0] r;
      if (s[SUM_WIDTH-1]) begin
         r = 8'd0;
      end else if (|s[SUM_WIDTH-2:16]) begin
         r = 8'd255;
      end else begin
         r = s[15:8];
      end
      return r;
   endfunction

   // Pick the pixel and convert
   always_comb begin
      luma  = sel_ff ? q_head.pix.luma1 : q_head.pix.luma0;
      c     = $signed({1'b0, luma}) - $signed({1'b0, LUMA_OFFSET});
      d     = $signed({1'b0, q_head.pix.chroma_blue}) - $signed({1'b0, CHROMA_OFFSET});
      e     = $signed({1'b0, q_head.pix.chroma_red}) - $signed({1'b0, CHROMA_OFFSET});
      c_x   = {{(SUM_WIDTH - 9){c[8]}}, c};
      d_x   = {{(SUM_WIDTH - 9){d[8]}}, d};
      e_x   = {{(SUM_WIDTH - 9){e[8]}}, e};
      sum_b = c_x * COEF_Y + d_x * COEF_B_CB + ROUND;
      sum_g = c_x * COEF_Y - d_x * COEF_G_CB - e_x * COEF_G_CR + ROUND;
      sum_r = c_x * COEF_Y + e_x * COEF_R_CR + ROUND;
   end

   assign final_pix = !q_head.two || sel_ff;
   assign load      = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop     = load && final_pix;

   // Build the next result beat
   always_comb begin
      out_in              = out_ff;
      out_in.blue         = sat8(sum_b);
      out_in.green        = sat8(sum_g);
      out_in.red          = sat8(sum_r);
      out_in.alpha        = ALPHA_OPAQUE;
      out_in.last         = final_pix;
      out_in.end_of_row   = final_pix && q_head.eor;
      out_in.end_of_frame = final_pix && q_head.eof;
   end

   // Hold the result until taken, step through the macropixel's pixels
   always_comb begin
      sel_in   = sel_ff;
      valid_in = valid_ff;
      if (load) begin
         sel_in   = !final_pix;
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         sel_ff   <= sel_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire
